FILE: design/tma_pkg.sv
package tma_pkg;

  // Block geometry.
  localparam int SAMPLES_PER_CHANNEL = 30;
  localparam int CHANNEL_COUNT       = 3;

  // Fixed field widths.
  localparam int SAMPLE_W = 12;
  localparam int CHAN_W   = 2;

  // Derived widths. The sum holds a full block of full-scale samples.
  localparam int SUM_W    = $clog2(SAMPLES_PER_CHANNEL * ((1 << SAMPLE_W) - 1) + 1);
  localparam int CNT_W    = $clog2(SAMPLES_PER_CHANNEL + 1);
  localparam int CH_IDX_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

  // The trimmed sum is divided by a constant through a reciprocal multiply.
  localparam int DIVISOR = SAMPLES_PER_CHANNEL - 2;
  localparam int RECIP_W = SUM_W + 1;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((1 << SUM_W) / DIVISOR);

  // One channel's accumulator entry.
  typedef struct packed {
    logic [SUM_W-1:0]    sum;
    logic [SAMPLE_W-1:0] max;
    logic [SAMPLE_W-1:0] min;
    logic [CNT_W-1:0]    cnt;
  } entry_t;

  // A completed block handed to the divider.
  typedef struct packed {
    logic [SUM_W-1:0]  trimmed;
    logic [CHAN_W-1:0] channel;
  } res_t;

endpackage

FILE: design/tma_if.sv
interface tma_in_if import tma_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  logic [CHAN_W-1:0]   channel;

  modport source (output valid, output sample, output channel, input ready);
  modport sink   (input valid, input sample, input channel, output ready);
endinterface

interface tma_out_if import tma_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] average;
  logic [CHAN_W-1:0]   result_channel;

  modport source (output valid, output average, output result_channel, input ready);
  modport sink   (input valid, input average, input result_channel, output ready);
endinterface

FILE: design/tma_cdiv.sv
// Divides the trimmed sum by the constant divisor: a reciprocal multiply,
// then a single correction step, then the output register.
module tma_cdiv import tma_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  req_valid_i,
  output logic  req_ready_o,
  input  res_t  req_i,
  tma_out_if.source out_o
);

  localparam int PROD_W = SUM_W + RECIP_W;

  logic                s2_v_q;
  res_t                s2_q;
  logic                s3_v_q;
  logic [SAMPLE_W-1:0] s3_qest_q;
  res_t                s3_q;
  logic                ov_q;
  logic [SAMPLE_W-1:0] avg_q;
  logic [CHAN_W-1:0]   och_q;

  logic                s3_move;
  logic                s2_move;
  logic [PROD_W-1:0]   prod;
  logic [SUM_W-1:0]    back;
  logic [SUM_W-1:0]    rem;
  logic [SAMPLE_W-1:0] quot;

  assign s3_move     = !ov_q || out_o.ready;
  assign s2_move     = !s3_v_q || s3_move;
  assign req_ready_o = !s2_v_q || s2_move;

  // The estimate is never above the true quotient and at most one below it.
  assign prod = PROD_W'(s2_q.trimmed) * PROD_W'(RECIP);
  assign back = SUM_W'(s3_qest_q) * SUM_W'(DIVISOR);
  assign rem  = s3_q.trimmed - back;
  assign quot = (rem >= SUM_W'(DIVISOR)) ? s3_qest_q + SAMPLE_W'(1) : s3_qest_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      if (req_ready_o) s2_v_q <= req_valid_i;
      if (s2_move)     s3_v_q <= s2_v_q;
      if (s3_move)     ov_q   <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_ready_o && req_valid_i) begin
      s2_q <= req_i;
    end
    if (s2_move && s2_v_q) begin
      s3_q      <= s2_q;
      s3_qest_q <= prod[SUM_W +: SAMPLE_W];
    end
    if (s3_move && s3_v_q) begin
      avg_q <= quot;
      och_q <= s3_q.channel;
    end
  end

  assign out_o.valid          = ov_q;
  assign out_o.average        = avg_q;
  assign out_o.result_channel = och_q;

endmodule

FILE: design/trimmed_mean_adc_filter.sv
// Channel  Direction  Payload                          Handshake
// in_i     sink       sample[11:0], channel[1:0]       valid/ready
// out_o    source     average[11:0], result_channel    valid/ready
//
// One sample is accepted every cycle unless the input stalls. A result
// passes from the accumulator update of the sample that completes its
// block through the reciprocal multiply and then the correction step,
// which loads the output register.
// The per-channel accumulators sit in a small memory with a registered read;
// back-to-back samples on the same channel take the freshly updated entry
// over a bypass path instead of the stale memory word.
// Reset clears all control state and marks every channel entry as empty.
// Input stalls only when a completing sample finds the divider and the
// output register full while the output side is held off.
module trimmed_mean_adc_filter import tma_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  tma_in_if.sink    in_i,
  tma_out_if.source out_o
);

  // Accumulator memory, one entry per channel, and the valid bit of each entry.
  // An entry that was never written reads as empty.
  entry_t                   mem [CHANNEL_COUNT];
  logic [CHANNEL_COUNT-1:0] vld_q;

  // Update stage: the sample waits here while its entry is read.
  logic                s1_v_q;
  logic [SAMPLE_W-1:0] s1_samp_q;
  logic [CH_IDX_W-1:0] s1_idx_q;
  logic                s1_ent_v_q;
  entry_t              rd_q;
  logic                byp_v_q;
  entry_t              byp_q;

  logic                accept;
  logic                in_ok;
  logic [CH_IDX_W-1:0] in_idx;
  logic                s1_move;
  logic                s1_fire;
  entry_t              cur;
  entry_t              upd;
  entry_t              wr_ent;
  logic                done;
  res_t                req;
  logic                req_ready;

  assign in_idx = in_i.channel[CH_IDX_W-1:0];
  // Channels beyond the configured count are taken and dropped.
  assign in_ok  = in_i.channel < CHAN_W'(CHANNEL_COUNT);
  assign accept = in_i.valid && in_i.ready;

  // The current entry: bypassed value when the previous sample updated the
  // same channel, otherwise the memory word, or empty if never written.
  always_comb begin
    if (byp_v_q) begin
      cur = byp_q;
    end else if (s1_ent_v_q) begin
      cur = rd_q;
    end else begin
      cur = '0;
    end
  end

  // The first sample of a block loads sum, max and min.
  always_comb begin
    upd = cur;
    if (cur.cnt == '0) begin
      upd.sum = SUM_W'(s1_samp_q);
      upd.max = s1_samp_q;
      upd.min = s1_samp_q;
    end else begin
      upd.sum = cur.sum + SUM_W'(s1_samp_q);
      if (s1_samp_q > cur.max) upd.max = s1_samp_q;
      if (s1_samp_q < cur.min) upd.min = s1_samp_q;
    end
    upd.cnt = cur.cnt + CNT_W'(1);
  end

  assign done   = upd.cnt == CNT_W'(SAMPLES_PER_CHANNEL);
  // A finished block leaves its channel cleared for the next one.
  assign wr_ent = done ? '0 : upd;

  assign req.trimmed = upd.sum - SUM_W'(upd.max) - SUM_W'(upd.min);
  assign req.channel = CHAN_W'(s1_idx_q);

  assign s1_move    = !(s1_v_q && done) || req_ready;
  assign s1_fire    = s1_v_q && s1_move;
  assign in_i.ready = !s1_v_q || s1_move;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      byp_v_q <= 1'b0;
      vld_q   <= '0;
    end else begin
      if (in_i.ready) begin
        s1_v_q <= accept && in_ok;
      end
      if (accept) begin
        byp_v_q <= s1_fire && (s1_idx_q == in_idx);
      end
      if (s1_fire) begin
        vld_q[s1_idx_q] <= 1'b1;
      end
    end
  end

  // Memory write of the updated entry and registered read for the next sample.
  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      mem[s1_idx_q] <= wr_ent;
    end
    if (accept) begin
      rd_q       <= mem[in_idx];
      s1_ent_v_q <= vld_q[in_idx];
      s1_samp_q  <= in_i.sample;
      s1_idx_q   <= in_idx;
      byp_q      <= wr_ent;
    end
  end

  tma_cdiv u_cdiv (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s1_v_q && done),
    .req_ready_o (req_ready),
    .req_i       (req),
    .out_o       (out_o)
  );

endmodule

FILE: design/tma_chk.sv
module tma_chk import tma_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [SAMPLE_W-1:0] out_average,
  input logic [CHAN_W-1:0]   out_channel
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(out_average) && $stable(out_channel))
    else $error("result changed while stalled");

  a_chan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_channel < CHAN_W'(CHANNEL_COUNT))
    else $error("result for a channel that does not exist");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

endmodule

bind trimmed_mean_adc_filter tma_chk u_tma_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready    (in_i.ready),
  .out_valid   (out_o.valid),
  .out_ready   (out_o.ready),
  .out_average (out_o.average),
  .out_channel (out_o.result_channel)
);
